// ----- src/mcptp_pkg.sv -----
package mcptp_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_BITS      = 6;
  localparam int NCH_BITS     = 7;
  localparam int WIN_BITS     = 10;
  localparam int ADDR_BITS    = 3;
  localparam int DATA_BITS    = 32;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [WIN_BITS-1:0] WINDOW_LENGTH_RESET   = 10'd10;
  localparam logic [NCH_BITS-1:0] ACTIVE_CHANNELS_RESET = 7'd64;

  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_ACTIVE_CHANNELS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SWEEP,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic                          rd_en;
    logic [CH_BITS-1:0]            rd_addr;
    logic                          wr_en;
    logic [CH_BITS-1:0]            wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_min;
    logic signed [SAMPLE_BITS-1:0] wr_max;
    logic                          clr;
  } mem_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] min;
    logic signed [SAMPLE_BITS-1:0] max;
  } mem_rsp_t;

endpackage

// ----- src/mcptp_track_mem.sv -----
module mcptp_track_mem (
  input  logic                clk,
  input  logic                rst,
  input  mcptp_pkg::mem_req_t req,
  output mcptp_pkg::mem_rsp_t rsp
);
  import mcptp_pkg::*;

  logic [2*SAMPLE_BITS-1:0] mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]  valid;
  logic [2*SAMPLE_BITS-1:0] rd_data;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_min, req.wr_max};
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.clr) begin
        valid <= '0;
      end else if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr] & ~req.clr;
      end
    end
  end

  assign rsp.min = rd_valid ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : SAMPLE_MAX;
  assign rsp.max = rd_valid ? rd_data[SAMPLE_BITS-1:0] : SAMPLE_MIN;

endmodule

// ----- src/mcptp_ctrl.sv -----
module mcptp_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [mcptp_pkg::WIN_BITS-1:0]        window_length,
  input  logic [mcptp_pkg::NCH_BITS-1:0]        active_channels,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mcptp_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [mcptp_pkg::CH_BITS-1:0]         channel_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mcptp_pkg::CH_BITS-1:0]         report_channel,
  output logic [mcptp_pkg::SAMPLE_BITS-1:0]     peak_to_peak,
  output logic                                  last_report,
  output mcptp_pkg::mem_req_t                   req,
  input  mcptp_pkg::mem_rsp_t                   rsp
);
  import mcptp_pkg::*;

  state_t                        state;
  state_t                        state_next;
  logic [WIN_BITS-1:0]           window_count;
  logic [CH_BITS-1:0]            sweep_idx;
  logic signed [SAMPLE_BITS-1:0] held_sample;
  logic [CH_BITS-1:0]            held_ch;

  logic [WIN_BITS-1:0]           win_eff;
  logic [NCH_BITS-1:0]           n_eff;
  logic [NCH_BITS-1:0]           n_dec;
  logic [CH_BITS-1:0]            n_m1;
  logic                          accept;
  logic                          window_end;
  logic                          start_sweep;
  logic                          sweep_last;
  logic                          out_free;
  logic                          out_load;
  logic                          ch_active;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        p2p;
  logic signed [SAMPLE_BITS-1:0] upd_min;
  logic signed [SAMPLE_BITS-1:0] upd_max;

  always_comb begin
    win_eff = (window_length == '0) ? WIN_BITS'(1) : window_length;
    if (active_channels == '0) begin
      n_eff = NCH_BITS'(1);
    end else if (active_channels > NCH_BITS'(MAX_CHANNELS)) begin
      n_eff = NCH_BITS'(MAX_CHANNELS);
    end else begin
      n_eff = active_channels;
    end
    n_dec = n_eff - NCH_BITS'(1);
    n_m1  = n_dec[CH_BITS-1:0];
  end

  assign accept      = in_valid && in_ready;
  assign window_end  = (window_count >= win_eff);
  assign start_sweep = accept && (channel_index == '0) && window_end;
  assign sweep_last  = (sweep_idx == n_m1);
  assign out_free    = !out_valid || out_ready;
  assign ch_active   = ({1'b0, held_ch} < n_eff);

  assign diff    = {rsp.max[SAMPLE_BITS-1], rsp.max} - {rsp.min[SAMPLE_BITS-1], rsp.min};
  assign p2p     = diff[SAMPLE_BITS] ? '0 : diff[SAMPLE_BITS-1:0];
  assign upd_min = (held_sample < rsp.min) ? held_sample : rsp.min;
  assign upd_max = (held_sample > rsp.max) ? held_sample : rsp.max;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_sweep) begin
          state_next = ST_SWEEP;
        end else if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_SWEEP: begin
        if (out_free && sweep_last) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    req.rd_en   = 1'b0;
    req.rd_addr = channel_index;
    req.wr_en   = 1'b0;
    req.wr_addr = held_ch;
    req.wr_min  = upd_min;
    req.wr_max  = upd_max;
    req.clr     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        req.rd_en = in_valid;
      end
      ST_SWEEP: begin
        out_load = out_free;
        if (out_free && !sweep_last) begin
          req.rd_en   = 1'b1;
          req.rd_addr = sweep_idx + CH_BITS'(1);
        end
      end
      ST_CLEAR: begin
        req.clr     = 1'b1;
        req.rd_en   = 1'b1;
        req.rd_addr = held_ch;
      end
      ST_UPDATE: begin
        req.wr_en = ch_active;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_count <= '0;
      sweep_idx    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (channel_index == '0)) begin
        window_count <= window_end ? WIN_BITS'(1) : window_count + WIN_BITS'(1);
      end
      if (start_sweep) begin
        sweep_idx <= '0;
      end else if (out_load) begin
        sweep_idx <= sweep_idx + CH_BITS'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_sample <= sample_value;
      held_ch     <= channel_index;
    end
    if (out_load) begin
      report_channel <= sweep_idx;
      peak_to_peak   <= p2p;
      last_report    <= sweep_last;
    end
  end

`ifndef SYNTHESIS
  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    start_sweep |=> state == ST_SWEEP)
    else $error("window end did not start a sweep");

  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    (out_load && sweep_last) |=> state == ST_CLEAR)
    else $error("last report did not clear the trackers");

  a_no_wr_clr: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.clr))
    else $error("tracker write during clear");

  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_report) |-> report_channel == n_m1)
    else $error("last report on wrong channel");
`endif

endmodule

// ----- src/multichannel_peak_to_peak_tracker.sv -----
// Tracks the minimum and maximum of interleaved signed samples for up to 64
// channels in a tracker memory and reports max minus min for channels
// 0 .. active_channels-1 whenever a channel-0 sample arrives after
// window_length channel-0 samples. An ordinary sample reads its channel's
// tracker entry when it is accepted and writes it back in the update state.
// A sample that closes a window first starts a sweep over the N reported
// channels: one report per cycle is read from the memory while the output
// is free, then the trackers are cleared and the sample is processed.
// No clearing pass is needed after reset. Registers: window_length at
// address 0, active_channels at address 4; write them only while idle.
module multichannel_peak_to_peak_tracker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [mcptp_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [mcptp_pkg::DATA_BITS-1:0]          pwdata,
  output logic [mcptp_pkg::DATA_BITS-1:0]          prdata,
  output logic                                     pready,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [mcptp_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [mcptp_pkg::CH_BITS-1:0]            channel_index,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [mcptp_pkg::CH_BITS-1:0]            report_channel,
  output logic [mcptp_pkg::SAMPLE_BITS-1:0]        peak_to_peak,
  output logic                                     last_report
);
  import mcptp_pkg::*;

  logic [WIN_BITS-1:0] window_length;
  logic [NCH_BITS-1:0] active_channels;
  logic                reg_index;
  mem_req_t            req;
  mem_rsp_t            rsp;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= WINDOW_LENGTH_RESET;
      active_channels <= ACTIVE_CHANNELS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_WINDOW_LENGTH:   window_length   <= pwdata[WIN_BITS-1:0];
        REG_ACTIVE_CHANNELS: active_channels <= pwdata[NCH_BITS-1:0];
        default:             window_length   <= window_length;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_WINDOW_LENGTH:   prdata = DATA_BITS'(window_length);
      REG_ACTIVE_CHANNELS: prdata = DATA_BITS'(active_channels);
      default:             prdata = '0;
    endcase
  end

  mcptp_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .window_length   (window_length),
    .active_channels (active_channels),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_value    (sample_value),
    .channel_index   (channel_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .report_channel  (report_channel),
    .peak_to_peak    (peak_to_peak),
    .last_report     (last_report),
    .req             (req),
    .rsp             (rsp)
  );

  mcptp_track_mem u_mem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

endmodule
